// ===== rtl/lzwc_pkg.sv =====
// Package for the LZ77 window copy block: sizes, token and status codes,
// controller states and the command/status structs. No dependencies.
`timescale 1ns / 1ps
package lzwc_pkg;
  localparam int WINDOW_BYTES     = 32768;
  localparam int WIN_AW           = $clog2(WINDOW_BYTES);
  localparam int BYTES_PER_RESULT = 8;
  localparam int FILL_W           = $clog2(BYTES_PER_RESULT + 1);
  localparam logic [8:0] MAX_MATCH = 9'd258;

  localparam logic [1:0] OP_LITERAL = 2'd0;
  localparam logic [1:0] OP_MATCH   = 2'd1;
  localparam logic [1:0] OP_EOB     = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_DIST = 2'd1;
  localparam logic [1:0] ST_CAPACITY = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_READ, S_COPY, S_EMIT
  } lzwc_state_t;

  typedef struct packed {
    logic       load;      // capture the token
    logic       lit_write; // write literal and post it
    logic       post_err;  // post an empty result with status
    logic [1:0] err_code;
    logic       copy_byte; // take the read byte into the pack
    logic       flush;     // post the pack
    logic       out_take;  // output register consumed
  } lzwc_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       bad_dist;
    logic       cap_lit;
    logic       cap_match;
    logic       len_zero;
    logic       copy_done;  // remaining count reaches zero after this byte
    logic       pack_full;  // pack holds a full result after this byte
    logic       out_full;
  } lzwc_sts_t;
endpackage

// ===== rtl/lzwc_datapath.sv =====
// Datapath: history window memory, position and capacity registers,
// match counters, byte packing and the output register. Uses lzwc_pkg.
`timescale 1ns / 1ps
module lzwc_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  lzwc_pkg::lzwc_cmd_t cmd,
  output lzwc_pkg::lzwc_sts_t sts,
  input  logic              cfg_we,
  input  logic [31:0]       cfg_out_capacity,
  input  logic [1:0]        in_op,
  input  logic [7:0]        in_literal,
  input  logic [8:0]        in_match_length,
  input  logic [15:0]       in_match_distance,
  output logic              out_valid,
  output logic [63:0]       out_out_bytes,
  output logic [3:0]        out_byte_count,
  output logic              out_last,
  output logic [1:0]        out_status
);
  import lzwc_pkg::*;

  logic [7:0]  win_mem [WINDOW_BYTES];
  logic [7:0]  rd_data_r;
  logic [31:0] pos_r, cap_r;
  logic [1:0]  op_r;
  logic [7:0]  lit_r;
  logic [8:0]  len_r;
  logic [15:0] dist_r;
  logic [63:0] pack_r;
  logic [FILL_W-1:0] fill_r;
  logic        ov_r;
  logic [63:0] ob_r;
  logic [3:0]  oc_r;
  logic        ol_r;
  logic [1:0]  os_r;
  logic [63:0] pack_nxt;
  logic [32:0] end_pos;

  always_comb begin
    end_pos = {1'b0, pos_r} + {24'd0, len_r};
    pack_nxt = pack_r | ({56'd0, rd_data_r} << {fill_r, 3'b000});
    sts.op        = op_r;
    sts.bad_dist  = (dist_r == 16'd0) || ({16'd0, dist_r} > pos_r)
                    || ({16'd0, dist_r} > 32'(WINDOW_BYTES));
    sts.cap_lit   = pos_r >= cap_r;
    sts.cap_match = end_pos > {1'b0, cap_r};
    sts.len_zero  = len_r == 9'd0;
    sts.copy_done = len_r == 9'd1;
    sts.pack_full = fill_r == FILL_W'(BYTES_PER_RESULT - 1);
    sts.out_full  = ov_r;
  end

  // Window: one write and one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.lit_write || cmd.copy_byte) begin
      win_mem[pos_r[WIN_AW-1:0]] <= cmd.lit_write ? lit_r : rd_data_r;
    end
    rd_data_r <= win_mem[pos_r[WIN_AW-1:0] - dist_r[WIN_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      cap_r  <= '1;
      ov_r   <= 1'b0;
      fill_r <= '0;
      pack_r <= '0;
    end else begin
      if (cfg_we) cap_r <= cfg_out_capacity;
      // A new result may replace one that is taken in the same cycle.
      if (cmd.lit_write || cmd.post_err || cmd.flush) begin
        ov_r <= 1'b1;
      end else if (cmd.out_take) begin
        ov_r <= 1'b0;
      end
      if (cmd.load) begin
        op_r   <= in_op;
        lit_r  <= in_literal;
        len_r  <= (in_match_length > MAX_MATCH) ? MAX_MATCH : in_match_length;
        dist_r <= in_match_distance;
      end
      if (cmd.load || cmd.flush) begin
        pack_r <= '0;
        fill_r <= '0;
      end else if (cmd.copy_byte) begin
        pack_r <= pack_nxt;
        fill_r <= fill_r + FILL_W'(1);
      end
      if (cmd.lit_write || cmd.copy_byte) pos_r <= pos_r + 32'd1;
      if (cmd.copy_byte) len_r <= len_r - 9'd1;
      if (cmd.lit_write) begin
        ob_r <= {56'd0, lit_r}; oc_r <= 4'd1; ol_r <= 1'b1; os_r <= ST_OK;
      end else if (cmd.post_err) begin
        ob_r <= '0; oc_r <= 4'd0; ol_r <= 1'b1; os_r <= cmd.err_code;
      end else if (cmd.flush) begin
        ob_r <= pack_nxt; oc_r <= 4'(fill_r) + 4'd1;
        ol_r <= sts.copy_done; os_r <= ST_OK;
      end
    end
  end

  assign out_valid      = ov_r;
  assign out_out_bytes  = ob_r;
  assign out_byte_count = oc_r;
  assign out_last       = ol_r;
  assign out_status     = os_r;
endmodule

// ===== rtl/lzwc_ctrl.sv =====
// Controller state machine for the LZ77 window copy block.
// Drives datapath commands from its status; uses lzwc_pkg.
`timescale 1ns / 1ps
module lzwc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              out_stall,
  input  lzwc_pkg::lzwc_sts_t sts,
  output lzwc_pkg::lzwc_cmd_t cmd
);
  import lzwc_pkg::*;

  lzwc_state_t state_r, state_nxt;
  logic out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    cmd.out_take = sts.out_full && !out_stall;
    out_free = !sts.out_full || !out_stall;
    in_stall = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: if (in_valid) begin
        cmd.load = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (sts.op == OP_MATCH && !sts.bad_dist && !sts.cap_match && !sts.len_zero) begin
          state_nxt = S_READ;
        end else if (sts.op == OP_LITERAL || sts.op == OP_MATCH || sts.op == OP_EOB) begin
          if (out_free) begin
            if (sts.op == OP_LITERAL && !sts.cap_lit) begin
              cmd.lit_write = 1'b1;
            end else begin
              cmd.post_err = 1'b1;
              if (sts.op == OP_LITERAL) cmd.err_code = ST_CAPACITY;
              else if (sts.op == OP_MATCH && sts.bad_dist) cmd.err_code = ST_BAD_DIST;
              else if (sts.op == OP_MATCH && sts.cap_match) cmd.err_code = ST_CAPACITY;
              else cmd.err_code = ST_OK;
            end
            state_nxt = S_IDLE;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_READ: state_nxt = S_COPY; // read address settles, data registered
      S_COPY: begin
        if (sts.copy_done || sts.pack_full) begin
          if (out_free) begin
            cmd.copy_byte = 1'b1;
            cmd.flush = 1'b1;
            state_nxt = sts.copy_done ? S_IDLE : S_READ;
          end
        end else begin
          cmd.copy_byte = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_EMIT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

// ===== rtl/lz77_window_copy.sv =====
// Top level of the LZ77 window copy block: joins controller and datapath.
// Depends on lzwc_pkg, lzwc_ctrl and lzwc_datapath.
`timescale 1ns / 1ps
// Usage. The input channel (in_valid/in_stall) takes one decoded DEFLATE
// token per request: a literal, a length/distance match or end of block.
// The result channel (out_valid/out_stall) carries packed output bytes, up
// to eight per request, first byte in the low bits, with last marking the
// final result of a token and status giving any error.
// cfg_we with cfg_out_capacity sets the output capacity; write it only when
// the block is idle.
// Sequencing: a literal, end of block or error is checked after acceptance
// and its result loaded into the output register, which waits while that
// register is full and stalled; the block then returns to idle for the
// next request. A match copies one byte at a time, each byte read from the
// window into a register (S_READ) before it is written back (S_COPY), and
// waits only when a full pack or its final bytes must be posted while the
// output register is full and stalled. One token is processed at a time.
// Reset clears the output position, sets the capacity to all ones and
// empties the output register; the window holds no data until written.
// When the receiver stalls, the result is held in the output register and
// the block waits only when it needs to post another result.
module lz77_window_copy (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_out_capacity,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [7:0]  in_literal,
  input  logic [8:0]  in_match_length,
  input  logic [15:0] in_match_distance,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_out_bytes,
  output logic [3:0]  out_byte_count,
  output logic        out_last,
  output logic [1:0]  out_status
);
  import lzwc_pkg::*;

  lzwc_cmd_t cmd;
  lzwc_sts_t sts;

  // Sequencing of each token.
  lzwc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_stall(out_stall), .sts(sts), .cmd(cmd)
  );

  // Window, counters, packing and output register.
  lzwc_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .cfg_we(cfg_we), .cfg_out_capacity(cfg_out_capacity),
    .in_op(in_op), .in_literal(in_literal), .in_match_length(in_match_length),
    .in_match_distance(in_match_distance),
    .out_valid(out_valid), .out_out_bytes(out_out_bytes),
    .out_byte_count(out_byte_count), .out_last(out_last), .out_status(out_status)
  );
endmodule

// ===== sim/tb_lz77_window_copy.sv =====
// Self-checking testbench for lz77_window_copy: directed table, window fill, random tokens.
// Depends on lzwc_pkg and the lz77_window_copy RTL; a predictor gives the expected results.
`timescale 1ns / 1ps
module tb_lz77_window_copy;
  import lzwc_pkg::*;

  // Token code that the block must swallow without any result.
  localparam logic [1:0] OP_UNDEF = 2'd3;
  // Drain time after the last expected result, to cover any busy tail.
  localparam int DRAIN_CYCLES = 600;
  localparam int HOLD_CYCLES  = 400;
  localparam int WATCHDOG     = 20000;

  typedef struct {
    logic [63:0] bytes;
    logic [3:0]  cnt;
    logic        last;
    logic [1:0]  status;
  } copy_res_t;

  typedef struct {
    logic [1:0]  op;
    logic [7:0]  lit;
    logic [8:0]  len;
    logic [15:0] mdist;
    bit          typed;    // expected result written in the row
    logic [63:0] bytes;
    logic [3:0]  cnt;
    logic [1:0]  status;
  } token_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [31:0] cfg_out_capacity;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_op;
  logic [7:0]  in_literal;
  logic [8:0]  in_match_length;
  logic [15:0] in_match_distance;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] out_out_bytes;
  logic [3:0]  out_byte_count;
  logic        out_last;
  logic [1:0]  out_status;

  // Predictor state: its own copy of the window, position and capacity.
  logic [7:0]  hist_mem [WINDOW_BYTES];
  int unsigned write_pos;
  int unsigned cap_bytes;

  copy_res_t   pending_results[$];
  int          error_count;
  int          idle_cycles;
  bit          hold_req;
  int          burst_left;

  lz77_window_copy u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_out_capacity (cfg_out_capacity),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_literal       (in_literal),
    .in_match_length  (in_match_length),
    .in_match_distance(in_match_distance),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_out_bytes    (out_out_bytes),
    .out_byte_count   (out_byte_count),
    .out_last         (out_last),
    .out_status       (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Works out the results of one token and moves the predictor state on.
  // Errors leave the window and the position untouched.
  task automatic predict_token(input logic [1:0] op, input logic [7:0] lit,
                               input logic [8:0] len_in, input logic [15:0] mdist,
                               ref copy_res_t res_q[$]);
    copy_res_t   r;
    logic [8:0]  len;
    logic [7:0]  b;
    int unsigned src;
    int          fill;
    int          i;
    r = '{64'd0, 4'd0, 1'b1, ST_OK};
    case (op)
      OP_LITERAL: begin
        if (write_pos >= cap_bytes) begin
          r.status = ST_CAPACITY;
        end else begin
          hist_mem[write_pos[WIN_AW-1:0]] = lit;
          write_pos++;
          r.bytes = {56'd0, lit};
          r.cnt   = 4'd1;
        end
        res_q.push_back(r);
      end
      OP_EOB: res_q.push_back(r);
      OP_MATCH: begin
        len = (len_in > MAX_MATCH) ? MAX_MATCH : len_in;
        if (mdist == 16'd0 || mdist > write_pos || mdist > WINDOW_BYTES) begin
          r.status = ST_BAD_DIST;
          res_q.push_back(r);
        end else if (longint'(write_pos) + len > longint'(cap_bytes)) begin
          r.status = ST_CAPACITY;
          res_q.push_back(r);
        end else if (len == 9'd0) begin
          res_q.push_back(r);
        end else begin
          fill = 0;
          r.bytes = '0;
          for (i = 0; i < len; i++) begin
            // Byte by byte, so an overlapping copy repeats what it just wrote.
            src = write_pos - mdist;
            b = hist_mem[src[WIN_AW-1:0]];
            hist_mem[write_pos[WIN_AW-1:0]] = b;
            write_pos++;
            r.bytes[8*fill +: 8] = b;
            fill++;
            if (fill == BYTES_PER_RESULT || i + 1 == len) begin
              r.cnt  = 4'(fill);
              r.last = (i + 1 == len);
              res_q.push_back(r);
              r.bytes = '0;
              fill = 0;
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  // Offers one request and holds it until accepted; the expectation is
  // queued at the acceptance edge. Bursts usually end in a random gap.
  task automatic send_token(input token_row_t t);
    copy_res_t res_q[$];
    copy_res_t r;
    in_valid          <= 1'b1;
    in_op             <= t.op;
    in_literal        <= t.lit;
    in_match_length   <= t.len;
    in_match_distance <= t.mdist;
    do @(posedge clk); while (in_stall);
    predict_token(t.op, t.lit, t.len, t.mdist, res_q);
    if (t.typed) begin
      r = '{t.bytes, t.cnt, 1'b1, t.status};
      pending_results.push_back(r);
    end else begin
      foreach (res_q[k]) pending_results.push_back(res_q[k]);
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  endtask

  function automatic token_row_t random_token();
    token_row_t  t;
    int unsigned reach;
    int unsigned pick;
    t = '{2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), 9'($urandom_range(0, 511)),
          16'($urandom_range(0, 65535)), 1'b0, '0, '0, '0};
    pick = $urandom_range(0, 99);
    if (pick < 40)      t.op = OP_LITERAL;
    else if (pick < 85) t.op = OP_MATCH;
    else if (pick < 95) t.op = OP_EOB;
    else                t.op = OP_UNDEF;
    if (t.op == OP_MATCH) begin
      // Mostly short, well-formed matches; now and then wild fields.
      if ($urandom_range(0, 9) < 8) t.len = 9'($urandom_range(3, 40));
      else if ($urandom_range(0, 1) == 0) t.len = 9'($urandom_range(41, 258));
      if ($urandom_range(0, 99) < 85) begin
        reach = (write_pos > WINDOW_BYTES) ? WINDOW_BYTES : write_pos;
        t.mdist = (reach == 0) ? 16'd1 : 16'($urandom_range(1, reach));
      end
    end
    return t;
  endfunction

  // Lowers valid and lets every expected result and any busy tail drain.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [31:0] value);
    wait_idle();
    cfg_we           <= 1'b1;
    cfg_out_capacity <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cap_bytes = value;
  endtask

  // Receiver: the stall pattern rotates among none, random and periodic stalls,
  // and a long hold-off is taken when the stimulus asks for one.
  initial begin
    int unsigned cyc;
    cyc = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else begin
        case ((cyc / 300) % 3)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 9) < 3);
          default: out_stall <= (cyc % 3 == 0);
        endcase
      end
    end
  end

  // Result checker: each accepted request is compared with the oldest
  // expectation, field by field.
  always @(posedge clk) begin
    copy_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: bytes %h count %0d", out_out_bytes, out_byte_count);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_out_bytes !== want.bytes) begin
          $error("out_bytes expected %h actual %h", want.bytes, out_out_bytes);
          error_count++;
        end
        if (out_byte_count !== want.cnt) begin
          $error("byte_count expected %0d actual %0d", want.cnt, out_byte_count);
          error_count++;
        end
        if (out_last !== want.last) begin
          $error("last expected %0d actual %0d", want.last, out_last);
          error_count++;
        end
        if (out_status !== want.status) begin
          $error("status expected %0d actual %0d", want.status, out_status);
          error_count++;
        end
      end
    end
  end

  // Watchdog: cycles without any accepted request on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Directed rows. Positions in the comments are those before the row.
  token_row_t directed[] = '{
    // Empty history: any distance is out of range.
    '{OP_MATCH,   8'h00, 9'd3,   16'd1,     1, 64'd0, 4'd0, ST_BAD_DIST},
    '{OP_EOB,     8'h00, 9'd0,   16'd0,     1, 64'd0, 4'd0, ST_OK},
    '{OP_LITERAL, 8'h00, 9'd0,   16'd0,     1, 64'h00, 4'd1, ST_OK},
    '{OP_LITERAL, 8'hFF, 9'd511, 16'hFFFF,  1, 64'hFF, 4'd1, ST_OK},
    '{OP_UNDEF,   8'h5A, 9'd7,   16'd1,     0, 64'd0, 4'd0, ST_OK},
    // Zero length is a valid but empty copy.
    '{OP_MATCH,   8'h00, 9'd0,   16'd1,     1, 64'd0, 4'd0, ST_OK},
    '{OP_MATCH,   8'h00, 9'd1,   16'd1,     0, 64'd0, 4'd0, ST_OK},
    '{OP_MATCH,   8'h00, 9'd2,   16'd2,     0, 64'd0, 4'd0, ST_OK},
    // Position is 5: a distance of exactly the position is allowed.
    '{OP_MATCH,   8'h00, 9'd3,   16'd5,     0, 64'd0, 4'd0, ST_OK},
    '{OP_MATCH,   8'h00, 9'd3,   16'd9,     1, 64'd0, 4'd0, ST_BAD_DIST},
    '{OP_MATCH,   8'h00, 9'd10,  16'd0,     1, 64'd0, 4'd0, ST_BAD_DIST},
    '{OP_MATCH,   8'h00, 9'd511, 16'hFFFF,  1, 64'd0, 4'd0, ST_BAD_DIST},
    '{OP_LITERAL, 8'hA5, 9'd0,   16'd0,     0, 64'd0, 4'd0, ST_OK},
    '{OP_MATCH,   8'h00, 9'd258, 16'd1,     0, 64'd0, 4'd0, ST_OK},
    // Over-long length is clamped to the longest match.
    '{OP_MATCH,   8'h00, 9'd511, 16'd7,     0, 64'd0, 4'd0, ST_OK},
    '{OP_MATCH,   8'h00, 9'd8,   16'd8,     0, 64'd0, 4'd0, ST_OK},
    '{OP_MATCH,   8'h00, 9'd16,  16'd3,     0, 64'd0, 4'd0, ST_OK},
    '{OP_MATCH,   8'h00, 9'd9,   16'd300,   0, 64'd0, 4'd0, ST_OK},
    '{OP_EOB,     8'h3C, 9'd256, 16'h8000,  1, 64'd0, 4'd0, ST_OK}
  };

  initial begin
    token_row_t  t;
    int          i;
    int unsigned reach;
    error_count = 0;
    idle_cycles = 0;
    hold_req    = 1'b0;
    burst_left  = 0;
    write_pos   = 0;
    cap_bytes   = 32'hFFFF_FFFF;
    foreach (hist_mem[k]) hist_mem[k] = 8'h00;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_out_capacity  = '0;
    in_valid          = 1'b0;
    in_op             = OP_LITERAL;
    in_literal        = '0;
    in_match_length   = '0;
    in_match_distance = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[k]) send_token(directed[k]);

    // Fill the whole window with long copies at legal distances so that the
    // largest distance becomes legal, then probe both sides of that edge.
    for (i = 0; i < 130; i++) begin
      t = random_token();
      t.op  = OP_MATCH;
      t.len = 9'd258;
      reach = (write_pos > WINDOW_BYTES) ? WINDOW_BYTES : write_pos;
      t.mdist = 16'($urandom_range(1, reach));
      send_token(t);
    end
    send_token('{OP_MATCH, 8'h00, 9'd3, 16'd32768, 0, 64'd0, 4'd0, ST_OK});
    send_token('{OP_MATCH, 8'h00, 9'd3, 16'd32769, 1, 64'd0, 4'd0, ST_BAD_DIST});

    // Long receiver hold-off while requests keep coming, so the input stalls.
    hold_req = 1'b1;
    for (i = 0; i < 25; i++) send_token(random_token());

    // Capacity a little above the position: copies run into the limit.
    write_capacity(write_pos + 300);
    for (i = 0; i < 100; i++) send_token(random_token());

    // Capacity of zero refuses every byte.
    write_capacity(32'd0);
    for (i = 0; i < 20; i++) send_token(random_token());

    // Capacity equal to the position: a literal fails, a zero-length copy passes.
    write_capacity(write_pos);
    send_token('{OP_LITERAL, 8'h81, 9'd0, 16'd0, 1, 64'd0, 4'd0, ST_CAPACITY});
    send_token('{OP_MATCH, 8'h00, 9'd0, 16'd1, 1, 64'd0, 4'd0, ST_OK});

    write_capacity(32'hFFFF_FFFF);
    for (i = 0; i < 50; i++) send_token(random_token());

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/lzwc_pkg.sv
rtl/lzwc_datapath.sv
rtl/lzwc_ctrl.sv
rtl/lz77_window_copy.sv
sim/tb_lz77_window_copy.sv
